@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check with no reset disable, so it is also live while reset is high.
`define ASSERT_NO_DISABLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/shp_pkg.sv @@
// Shared types and constants of the 3x3 RGB sharpen filter.
package shp_pkg;

  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 3 * CHAN_W;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int TAPS         = 9;
  localparam int CENTRE_TAP   = 4;
  localparam int WINDOW_TAPS  = 6;
  localparam int MAX_RESULTS  = 3;
  localparam int CNT_W        = 2;
  localparam int MIN_DIM      = 3;
  localparam int CENTRE_GAIN  = 9;
  localparam int CHAN_MAX     = 255;

  typedef logic [PIX_W-1:0]       pixel_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Register indexes on the configuration port
  localparam cfg_index_t REG_IMAGE_WIDTH  = cfg_index_t'(0);
  localparam cfg_index_t REG_IMAGE_HEIGHT = cfg_index_t'(1);

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd768;

  // One line buffer entry: pixel two rows up and one row up
  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } lb_entry_t;

  typedef struct packed {
    pixel_t           px;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } result_t;

  // All results caused by one input pixel, packed from slot 0
  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    result_t [MAX_RESULTS-1:0]       slot;
  } bundle_t;

endpackage

@@ hw/rtl/shp_line_buffer.sv @@
// Two-row line buffer memory: one read port and one write port, registered read.
module shp_line_buffer #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output shp_pkg::lb_entry_t  rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  shp_pkg::lb_entry_t  wr_data
);
  import shp_pkg::*;

  lb_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while the requesting stage waits
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/shp_kernel.sv @@
// 3x3 sharpen kernel: nine times the centre minus the eight neighbours, clamped.
module shp_kernel (
  input  shp_pkg::pixel_t nb [shp_pkg::TAPS],
  output shp_pkg::pixel_t sharp
);
  import shp_pkg::*;

  // 9*255 down to -8*255 fits in 13 bits two's complement
  localparam int ACC_W = 13;

  logic [ACC_W-1:0] acc [3];

  always_comb begin
    sharp = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = ACC_W'(CENTRE_GAIN * int'(nb[CENTRE_TAP][ch*CHAN_W +: CHAN_W]));
      for (int k = 0; k < TAPS; k++) begin
        if (k != CENTRE_TAP) begin
          acc[ch] = acc[ch] - ACC_W'(nb[k][ch*CHAN_W +: CHAN_W]);
        end
      end
      // clamp to the channel range
      if (acc[ch][ACC_W-1]) begin
        sharp[ch*CHAN_W +: CHAN_W] = '0;
      end else if (|acc[ch][ACC_W-2:CHAN_W]) begin
        sharp[ch*CHAN_W +: CHAN_W] = CHAN_W'(CHAN_MAX);
      end else begin
        sharp[ch*CHAN_W +: CHAN_W] = acc[ch][CHAN_W-1:0];
      end
    end
  end

endmodule

@@ hw/rtl/shp_emitter.sv @@
// Result bundle register and output register: sends one result per transfer.
module shp_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  shp_pkg::bundle_t  load,
  output logic              load_ready,
  output logic              result_valid,
  input  logic              result_stall,
  output shp_pkg::result_t  res,
  output logic              res_last
);
  import shp_pkg::*;

  logic             b_valid;
  logic [CNT_W-1:0] b_cnt;
  logic [CNT_W-1:0] b_idx;
  result_t          b_slot [MAX_RESULTS];

  logic out_free;
  logic emit;
  logic b_last;

  // output register can take a result when empty or being drained
  assign out_free   = !result_valid || !result_stall;
  assign emit       = b_valid && out_free;
  assign b_last     = (b_idx == b_cnt - CNT_W'(1));
  assign load_ready = !b_valid || (emit && b_last);

  // bundle control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= '0;
      b_cnt   <= '0;
    end else if (load_valid && load_ready) begin
      b_valid <= 1'b1;
      b_idx   <= '0;
      b_cnt   <= load.cnt;
    end else if (emit && b_last) begin
      b_valid <= 1'b0;
    end else if (emit) begin
      b_idx <= b_idx + CNT_W'(1);
    end
  end

  // bundle payload
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        b_slot[i] <= load.slot[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res      <= b_slot[b_idx];
      res_last <= b_last;
    end
  end

endmodule

@@ hw/rtl/sharpen_3x3_rgb_clamped_unit.sv @@
// Top level of the streaming 3x3 RGB sharpen filter with clamped output.
//
// Usage: RGB pixels enter in raster order on the pixel channel (pixel_valid,
// pixel_stall); a pixel transfers at a clock edge with valid high and stall low.
// Results leave on the result channel (result_valid, result_stall) with their
// column and row; last_in_run marks the final result caused by one input pixel.
// Interior pixels are sharpened and clamped, border pixels pass through, and
// frames narrower or shorter than three pass every pixel through unchanged.
// A pixel's first result passes the input, bundle and output registers.
// Throughput: one pixel per cycle while each pixel causes at most one result and
// result_stall is low; a pixel below row 0 in the last column, or in the bottom
// row past column 0, causes two or three results, one per cycle through the
// output register while unstalled, and holds the input off meanwhile. Outside
// pass-through frames, row 0 pixels cause no result. The line buffer is read at
// the pixel transfer and written as the pixel leaves the input register.
// Configuration writes (cfg_valid, cfg_ready) set width and height and restart
// the frame at column 0, row 0; they must be made only while the block is idle,
// which the block does not enforce. Reset clears all control state; line buffer
// contents stay undefined and are never used before being written. A stalled
// receiver fills the output register and bundle, then pixel_stall rises.
module sharpen_3x3_rgb_clamped_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [shp_pkg::CHAN_W-1:0]          red_in,
  input  logic [shp_pkg::CHAN_W-1:0]          green_in,
  input  logic [shp_pkg::CHAN_W-1:0]          blue_in,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [shp_pkg::CHAN_W-1:0]          red_out,
  output logic [shp_pkg::CHAN_W-1:0]          green_out,
  output logic [shp_pkg::CHAN_W-1:0]          blue_out,
  output logic [shp_pkg::COL_W-1:0]           out_col,
  output logic [shp_pkg::ROW_W-1:0]           out_row,
  output logic                                last_in_run,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  shp_pkg::cfg_index_t                 cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import shp_pkg::*;

  `include "assert_macros.svh"

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = CW + 1;
  localparam int HCW = RW + 1;

  // configuration registers and effective frame size
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WCW-1:0]          w_eff;
  logic [HCW-1:0]          h_eff;
  logic [WCW-1:0]          w_last_full;
  logic [HCW-1:0]          h_last_full;
  logic [CW-1:0]           w_last;
  logic [RW-1:0]           h_last;
  logic                    tiny_frame;
  logic                    cfg_write;

  // position of the next input pixel
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [CW-1:0] col_cnt_next;
  logic [RW-1:0] row_cnt_next;

  // input stage
  logic          pixel_accept;
  logic          a_valid;
  pixel_t        a_px;
  logic [CW-1:0] a_c;
  logic [RW-1:0] a_r;
  logic          a_xfer;

  // line buffer and window
  lb_entry_t lb_rd;
  lb_entry_t lb_wr;
  logic      lb_wr_en;
  pixel_t    window [WINDOW_TAPS];
  pixel_t    nb [TAPS];
  pixel_t    sharp;

  // result candidates
  logic    e1, e2, e3;
  result_t res1, res2, res3;
  bundle_t bundle;
  logic    load_valid;
  logic    load_ready;
  result_t res;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // configuration register writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize as the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = WCW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HCW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(image_height);
    end
  end

  assign w_last_full = w_eff - WCW'(1);
  assign h_last_full = h_eff - HCW'(1);
  assign w_last      = w_last_full[CW-1:0];
  assign h_last      = h_last_full[RW-1:0];
  assign tiny_frame  = (w_eff < WCW'(MIN_DIM)) || (h_eff < HCW'(MIN_DIM));

  // handshake of the input stage
  assign a_xfer       = a_valid && ((bundle.cnt == '0) || load_ready);
  assign pixel_stall  = a_valid && !a_xfer;
  assign pixel_accept = pixel_valid && !pixel_stall;

  // raster counters
  always_comb begin
    col_cnt_next = col_cnt + CW'(1);
    row_cnt_next = row_cnt;
    if (col_cnt == w_last) begin
      col_cnt_next = '0;
      row_cnt_next = (row_cnt == h_last) ? '0 : row_cnt + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cfg_write && ((cfg_index == REG_IMAGE_WIDTH) ||
                               (cfg_index == REG_IMAGE_HEIGHT))) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (pixel_accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pixel_accept) begin
      a_valid <= 1'b1;
    end else if (a_xfer) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      a_px <= {red_in, green_in, blue_in};
      a_c  <= col_cnt;
      a_r  <= row_cnt;
    end
  end

  // line buffer: read at the pixel transfer, written when the pixel moves on
  assign lb_wr_en    = a_xfer && !tiny_frame;
  assign lb_wr.upper = lb_rd.lower;
  assign lb_wr.lower = a_px;

  shp_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (pixel_accept),
    .rd_addr (col_cnt),
    .rd_data (lb_rd),
    .wr_en   (lb_wr_en),
    .wr_addr (a_c),
    .wr_data (lb_wr)
  );

  // window: columns c-2 and c-1, rows r-2 to r
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_TAPS; i++) begin
        window[i] <= '0;
      end
    end else if (lb_wr_en) begin
      window[0] <= window[3];
      window[1] <= window[4];
      window[2] <= window[5];
      window[3] <= lb_rd.upper;
      window[4] <= lb_rd.lower;
      window[5] <= a_px;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_TAPS; i++) begin
      nb[i] = window[i];
    end
    nb[6] = lb_rd.upper;
    nb[7] = lb_rd.lower;
    nb[8] = a_px;
  end

  shp_kernel u_kernel (
    .nb    (nb),
    .sharp (sharp)
  );

  // candidates: delayed centre, right border, bottom border
  always_comb begin
    e1 = (a_r != '0) && (a_c != '0);
    e2 = (a_r != '0) && (a_c == w_last);
    e3 = (a_r == h_last);

    res1.px  = ((a_c == CW'(1)) || (a_r == RW'(1))) ? window[4] : sharp;
    res1.col = COL_W'(a_c - CW'(1));
    res1.row = ROW_W'(a_r - RW'(1));

    res2.px  = lb_rd.lower;
    res2.col = COL_W'(a_c);
    res2.row = ROW_W'(a_r - RW'(1));

    res3.px  = a_px;
    res3.col = COL_W'(a_c);
    res3.row = ROW_W'(a_r);
  end

  // pack the results of this pixel from slot 0
  always_comb begin
    bundle.slot[2] = res3;
    if (tiny_frame) begin
      bundle.cnt     = CNT_W'(1);
      bundle.slot[0] = res3;
      bundle.slot[1] = res3;
    end else begin
      bundle.cnt     = CNT_W'(e1) + CNT_W'(e2) + CNT_W'(e3);
      bundle.slot[0] = e1 ? res1 : (e2 ? res2 : res3);
      bundle.slot[1] = e1 ? (e2 ? res2 : res3) : res3;
    end
  end

  assign load_valid = a_valid && (bundle.cnt != '0);

  shp_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load         (bundle),
    .load_ready   (load_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res          (res),
    .res_last     (last_in_run)
  );

  assign red_out   = res.px[3*CHAN_W-1:2*CHAN_W];
  assign green_out = res.px[2*CHAN_W-1:CHAN_W];
  assign blue_out  = res.px[CHAN_W-1:0];
  assign out_col   = res.col;
  assign out_row   = res.row;

  // checks
  `ASSERT_IMPLIES(a_lb_no_collision, lb_wr_en && pixel_accept, a_c != col_cnt, "lb port clash")
  `ASSERT_ALWAYS(a_col_in_range, col_cnt <= w_last, "column counter past frame width")
  `ASSERT_IMPLIES(a_tiny_one, a_valid && tiny_frame, bundle.cnt == CNT_W'(1), "tiny frame count")
  `ASSERT_NO_DISABLE(a_out_idle_after_reset, rst, ##1 !result_valid, "valid after reset")

endmodule

@@ test/sharpen_result_checker.sv @@
// Result checker for the 3x3 RGB sharpen filter: tracks the frame, predicts and compares output.
`timescale 1ns / 100ps

module sharpen_result_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  input  logic                             pixel_stall,
  input  logic [shp_pkg::CHAN_W-1:0]       red_in,
  input  logic [shp_pkg::CHAN_W-1:0]       green_in,
  input  logic [shp_pkg::CHAN_W-1:0]       blue_in,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic [shp_pkg::CHAN_W-1:0]       red_out,
  input  logic [shp_pkg::CHAN_W-1:0]       green_out,
  input  logic [shp_pkg::CHAN_W-1:0]       blue_out,
  input  logic [shp_pkg::COL_W-1:0]        out_col,
  input  logic [shp_pkg::ROW_W-1:0]        out_row,
  input  logic                             last_in_run,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  shp_pkg::cfg_index_t              cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               error_count,
  output int                               pending_count
);
  import shp_pkg::*;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } out_pixel_t;

  // expected output pixels, oldest first
  out_pixel_t expected_px_q[$];

  // shadow of the filter state
  pixel_t                  upper_line [MAX_WIDTH];
  pixel_t                  lower_line [MAX_WIDTH];
  pixel_t                  win_cols [WINDOW_TAPS];
  int                      next_col;
  int                      next_row;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      fail_total = 0;

  assign error_count = fail_total;

  // one channel of 9*centre minus the eight neighbours, clamped to the channel range
  function automatic logic [CHAN_W-1:0] sharpen_chan(input pixel_t nb [TAPS], input int sh);
    int acc;
    acc = CENTRE_GAIN * int'(nb[CENTRE_TAP][sh +: CHAN_W]);
    for (int k = 0; k < TAPS; k++)
      if (k != CENTRE_TAP) acc -= int'(nb[k][sh +: CHAN_W]);
    if (acc > CHAN_MAX) acc = CHAN_MAX;
    if (acc < 0) acc = 0;
    return CHAN_W'(acc);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endfunction

  // work out the output pixels caused by one input pixel and advance the frame position
  task automatic predict_sharpen(input pixel_t px);
    int         w, h, c, r, n;
    pixel_t     up, mid;
    pixel_t     nb [TAPS];
    pixel_t     res_px [MAX_RESULTS];
    int         res_col [MAX_RESULTS];
    int         res_row [MAX_RESULTS];
    out_pixel_t e;

    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    n = 0;

    if (w < MIN_DIM || h < MIN_DIM) begin
      // tiny frame: straight pass-through
      res_px[n] = px; res_col[n] = c; res_row[n] = r; n++;
    end else begin
      up  = upper_line[c];
      mid = lower_line[c];
      // pixel one column left and one row up now has its full window
      if (r >= 1 && c >= 1) begin
        if (c == 1 || r == 1) begin
          res_px[n] = win_cols[CENTRE_TAP];
        end else begin
          for (int k = 0; k < WINDOW_TAPS; k++) nb[k] = win_cols[k];
          nb[WINDOW_TAPS]     = up;
          nb[WINDOW_TAPS + 1] = mid;
          nb[WINDOW_TAPS + 2] = px;
          res_px[n] = {sharpen_chan(nb, 2 * CHAN_W), sharpen_chan(nb, CHAN_W),
                       sharpen_chan(nb, 0)};
        end
        res_col[n] = c - 1; res_row[n] = r - 1; n++;
      end
      // right border of the row above
      if (r >= 1 && c == w - 1) begin
        res_px[n] = mid; res_col[n] = c; res_row[n] = r - 1; n++;
      end
      // bottom row passes through
      if (r == h - 1) begin
        res_px[n] = px; res_col[n] = c; res_row[n] = r; n++;
      end
      upper_line[c] = mid;
      lower_line[c] = px;
      for (int k = 0; k < WINDOW_TAPS / 2; k++) win_cols[k] = win_cols[k + WINDOW_TAPS / 2];
      win_cols[3] = up;
      win_cols[4] = mid;
      win_cols[5] = px;
    end

    for (int k = 0; k < n; k++) begin
      e.red   = res_px[k][PIX_W-1 -: CHAN_W];
      e.green = res_px[k][2*CHAN_W-1 -: CHAN_W];
      e.blue  = res_px[k][CHAN_W-1:0];
      e.col   = COL_W'(res_col[k]);
      e.row   = ROW_W'(res_row[k]);
      e.last  = (k == n - 1);
      expected_px_q.push_back(e);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // result check first, then register writes, then new pixels
  always @(posedge clk) begin
    out_pixel_t want;
    if (rst) begin
      expected_px_q.delete();
      for (int k = 0; k < MAX_WIDTH; k++) begin
        upper_line[k] = '0;
        lower_line[k] = '0;
      end
      for (int k = 0; k < WINDOW_TAPS; k++) win_cols[k] = '0;
      next_col   = 0;
      next_row   = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_px_q.size() == 0) begin
          $error("unexpected result transfer at col %0d row %0d", out_col, out_row);
          fail_total++;
        end else begin
          want = expected_px_q.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("out_col", want.col, out_col);
          check_field("out_row", want.row, out_row);
          check_field("last_in_run", want.last, last_in_run);
        end
      end
      // any known register restarts the frame; unknown indexes do nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[WIDTH_REG_W-1:0];
            next_col  = 0;
            next_row  = 0;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_REG_W-1:0];
            next_col   = 0;
            next_row   = 0;
          end
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) predict_sharpen({red_in, green_in, blue_in});
    end
    pending_count <= expected_px_q.size();
  end

endmodule

@@ test/tb_sharpen_3x3_rgb_clamped_unit.sv @@
// Testbench top for the 3x3 RGB sharpen filter: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 100ps

module tb_sharpen_3x3_rgb_clamped_unit;
  import shp_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RANDOM_PIXELS = 200;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RESET_CYCLES  = 8;
  localparam int RUN_LIMIT_NS  = 36_000_000;

  // indexes past the register list, ignored by the block
  localparam cfg_index_t REG_UNMAPPED_LO = cfg_index_t'(2);
  localparam cfg_index_t REG_UNMAPPED_HI = cfg_index_t'(3);

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  pixel_valid  = 1'b0;
  logic                  pixel_stall;
  logic [CHAN_W-1:0]     red_in       = '0;
  logic [CHAN_W-1:0]     green_in     = '0;
  logic [CHAN_W-1:0]     blue_in      = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [CHAN_W-1:0]     red_out;
  logic [CHAN_W-1:0]     green_out;
  logic [CHAN_W-1:0]     blue_out;
  logic [COL_W-1:0]      out_col;
  logic [ROW_W-1:0]      out_row;
  logic                  last_in_run;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index    = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  int                    fail_count;
  int                    pending_results;

  sharpen_3x3_rgb_clamped_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .out_col      (out_col),
    .out_row      (out_row),
    .last_in_run  (last_in_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sharpen_result_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) result_check (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .out_col       (out_col),
    .out_row       (out_row),
    .last_in_run   (last_in_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (fail_count),
    .pending_count (pending_results)
  );

  always #6 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver backpressure: bursts of free cycles and stalls, mostly short
  initial begin
    int free_len, hold_len;
    forever begin
      free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      repeat (free_len) begin
        @(negedge clk);
        result_stall <= 1'b0;
      end
      repeat (hold_len) begin
        @(negedge clk);
        result_stall <= 1'b1;
      end
    end
  end

  // channel value with extra weight on the extremes
  function automatic logic [CHAN_W-1:0] pick_chan();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CHAN_W'($urandom);
  endfunction

  function automatic int pick_gap(input bit gappy);
    int roll;
    if (!gappy) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one pixel transfer; valid stays up afterwards unless the next call idles first
  task automatic send_pixel(input logic [CHAN_W-1:0] red, grn, blu, input int gap);
    repeat (gap) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
    end
    @(negedge clk);
    pixel_valid <= 1'b1;
    red_in      <= red;
    green_in    <= grn;
    blue_in     <= blu;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  // hold the sender off until every expected pixel is out, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // frame size with random junk in the unused upper data bits
  task automatic set_frame(input int w, input int h);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
    write_reg(REG_IMAGE_WIDTH, data);
    data = CFG_DATA_W'($urandom);
    data[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(h);
    write_reg(REG_IMAGE_HEIGHT, data);
  endtask

  initial begin
    int k, w, h, fw, fh, n, sel, hold_at, random_sent;
    bit gappy;

    random_sent = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // reset frame size: top row only, nothing comes out
    send_pixel(8'hFF, 8'h00, 8'hFF, 0);
    send_pixel(8'h00, 8'hFF, 8'h00, 0);

    // 3x3 frame: red clamps high, green clamps low, blue flat
    set_frame(MIN_DIM, MIN_DIM);
    for (k = 0; k < 9; k++)
      send_pixel((k == CENTRE_TAP) ? 8'hFF : 8'h00, (k == CENTRE_TAP) ? 8'h00 : 8'hFF,
                 8'd100, 0);
    // frame wraps; opposite clamps, plus an ignored register write mid-frame
    for (k = 0; k < 9; k++) begin
      if (k == CENTRE_TAP) write_reg(REG_UNMAPPED_LO, '1);
      send_pixel((k == CENTRE_TAP) ? 8'h00 : 8'hFF, (k == CENTRE_TAP) ? 8'hFF : 8'h00,
                 8'd100, pick_gap(1'b1));
    end

    // zero sizes act as one: each pixel is a whole frame
    set_frame(0, 0);
    send_pixel(8'h5A, 8'hA5, 8'h3C, 0);
    send_pixel(8'hC3, 8'h0F, 8'hF0, 0);
    // narrow frame passes through
    set_frame(2, 5);
    for (k = 0; k < 3; k++) send_pixel(pick_chan(), pick_chan(), pick_chan(), 0);

    // random frames, mostly complete, some cut short, a few odd sizes
    while (random_sent < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 8);
      if (sel < 6) begin
        w = $urandom_range(3, 10);
        h = $urandom_range(3, 6);
      end else if (sel == 6) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 8);
      end else if (sel == 7) begin
        w = $urandom_range(3, 12);
        h = $urandom_range(0, 2);
      end else begin
        // height past the maximum, only the first rows sent
        w = $urandom_range(3, 6);
        h = $urandom_range(MAX_HEIGHT + 1, (1 << HEIGHT_REG_W) - 1);
      end
      set_frame(w, h);
      fw = (w == 0) ? 1 : w;
      fh = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      if (sel == 8) n = fw * $urandom_range(3, 6);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, fw * fh);
      else n = fw * fh * $urandom_range(1, 2);
      gappy   = ($urandom_range(0, 3) != 0);
      hold_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
      for (k = 0; k < n; k++) begin
        if (k == hold_at) begin
          if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
          else drain_results();
        end
        send_pixel(pick_chan(), pick_chan(), pick_chan(), pick_gap(gappy));
      end
      random_sent += n;
    end

    drain_results();
    if (fail_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sharpen_3x3_rgb_clamped_unit.f @@
+incdir+hw/rtl
hw/rtl/shp_pkg.sv
hw/rtl/shp_line_buffer.sv
hw/rtl/shp_kernel.sv
hw/rtl/shp_emitter.sv
hw/rtl/sharpen_3x3_rgb_clamped_unit.sv
test/sharpen_result_checker.sv
test/tb_sharpen_3x3_rgb_clamped_unit.sv
